>>> src/ptp_pkg.sv
// package for the point transform with perspective divide
// holds beat structs, register indexes and fixed point constants; no dependencies
package ptp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 64;
    localparam int IDX_W     = 3;
    localparam int QUO_W     = DATA_W + FRAC_BITS + 1;
    localparam int DIV_STEPS = QUO_W;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW0_COLS_01 = 3'd0,
        REG_ROW0_COLS_23 = 3'd1,
        REG_ROW1_COLS_01 = 3'd2,
        REG_ROW1_COLS_23 = 3'd3,
        REG_ROW2_COLS_01 = 3'd4,
        REG_ROW2_COLS_23 = 3'd5,
        REG_ROW3_COLS_01 = 3'd6,
        REG_ROW3_COLS_23 = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     divide_applied;
        logic                     saturated;
    } result_t;

    localparam logic [CFG_W-1:0] FX_ONE64 = 64'(1) << FRAC_BITS;

endpackage

>>> src/ptp_div.sv
// pipelined restoring divider for (v << FRAC_BITS) / w, truncated toward zero
// one quotient bit per stage; depends on ptp_pkg
module ptp_div
    import ptp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [QUO_W-1:0]         in_num,
    input  logic [DATA_W-1:0]        in_den,
    input  logic                     in_neg,
    output logic                     out_valid,
    output logic [QUO_W-1:0]         out_quo,
    output logic                     out_neg
);

    logic                            vld_reg [DIV_STEPS];
    logic [QUO_W-1:0]                num_reg [DIV_STEPS];
    logic [DATA_W:0]                 rem_reg [DIV_STEPS];
    logic [DATA_W-1:0]               den_reg [DIV_STEPS];
    logic                            neg_reg [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic              vld_in;
        logic [QUO_W-1:0]  num_in;
        logic [DATA_W:0]   rem_in;
        logic [DATA_W-1:0] den_in;
        logic              neg_in;
        logic [DATA_W+1:0] trial;
        logic [DATA_W+1:0] shifted;
        if (s == 0) begin : g_first
            assign vld_in = in_valid;
            assign num_in = in_num;
            assign rem_in = '0;
            assign den_in = in_den;
            assign neg_in = in_neg;
        end
        else begin : g_next
            assign vld_in = vld_reg[s-1];
            assign num_in = num_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign neg_in = neg_reg[s-1];
        end
        always_comb
        begin
            shifted = {rem_in, num_in[QUO_W-1]};
            trial   = shifted - {2'b00, den_in};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= vld_in;
        end
        always_ff @(posedge clk)
        begin
            den_reg[s] <= den_in;
            neg_reg[s] <= neg_in;
            if (!trial[DATA_W+1])
            begin
                rem_reg[s] <= trial[DATA_W:0];
                num_reg[s] <= {num_in[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s] <= shifted[DATA_W:0];
                num_reg[s] <= {num_in[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_quo   = num_reg[DIV_STEPS-1];
    assign out_neg   = neg_reg[DIV_STEPS-1];

endmodule

>>> src/point_transform_perspective.sv
// top level of the homogeneous point transform with perspective divide
// matrix registers, multiply-add stages, w test and three dividers; uses ptp_pkg, ptp_div
//
// channel   signals                      dir  beat taken when
// point     start, busy, point           in   start && !busy
// result    done, result                 out  done (one cycle, no back pressure)
// config    cfg_we, cfg_idx, cfg_data    in   cfg_we
//
// one point per cycle; busy is tied low
// a point runs through products, sum, clamp, magnitudes, divider, output register
// reset loads the identity matrix and empties the pipeline
// the receiver cannot stall, so nothing in the pipeline ever holds
module point_transform_perspective
    import ptp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  point_t            point,
    output logic              done,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_idx,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int PW = 2 * DATA_W;
    localparam int SW = PW + 3;

    logic [CFG_W-1:0] mat_reg [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[REG_ROW0_COLS_01] <= FX_ONE64;
            mat_reg[REG_ROW0_COLS_23] <= '0;
            mat_reg[REG_ROW1_COLS_01] <= FX_ONE64 << DATA_W;
            mat_reg[REG_ROW1_COLS_23] <= '0;
            mat_reg[REG_ROW2_COLS_01] <= '0;
            mat_reg[REG_ROW2_COLS_23] <= FX_ONE64;
            mat_reg[REG_ROW3_COLS_01] <= '0;
            mat_reg[REG_ROW3_COLS_23] <= FX_ONE64 << DATA_W;
        end
        else if (cfg_we)
            mat_reg[cfg_idx] <= cfg_data;
    end

    function automatic logic signed [DATA_W-1:0] elem(input logic [CFG_W-1:0] r, input logic hi);
        return hi ? signed'(r[2*DATA_W-1:DATA_W]) : signed'(r[DATA_W-1:0]);
    endfunction

    assign busy = 1'b0;

    // stage 1: products
    logic                      v1_reg;
    logic signed [PW-1:0]      prod_reg [4][3];
    logic signed [DATA_W-1:0]  tr_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    for (genvar c = 0; c < 4; c++) begin : g_col
        always_ff @(posedge clk)
        begin
            prod_reg[c][0] <= PW'(point.point_x) * PW'(elem(mat_reg[c/2], c%2 == 1));
            prod_reg[c][1] <= PW'(point.point_y) * PW'(elem(mat_reg[2 + c/2], c%2 == 1));
            prod_reg[c][2] <= PW'(point.point_z) * PW'(elem(mat_reg[4 + c/2], c%2 == 1));
            tr_reg[c]      <= elem(mat_reg[6 + c/2], c%2 == 1);
        end
    end

    // stage 2: sum with rounding, then scale
    logic                  v2_reg;
    logic signed [SW-1:0]  t_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    for (genvar c = 0; c < 4; c++) begin : g_sum
        logic signed [SW-1:0] acc;
        always_comb
        begin
            acc = SW'(prod_reg[c][0]) + SW'(prod_reg[c][1]) + SW'(prod_reg[c][2])
                + (SW'(tr_reg[c]) <<< FRAC_BITS) + SW'(FX_ONE64 >> 1);
        end
        always_ff @(posedge clk)
            t_reg[c] <= acc >>> FRAC_BITS;
    end

    // stage 3: clamp and w test
    localparam logic signed [SW-1:0] S_MAX = SW'((longint'(1) <<< (DATA_W-1)) - 1);
    localparam logic signed [SW-1:0] S_MIN = ~S_MAX;

    logic                      v3_reg;
    logic signed [DATA_W-1:0]  c_reg [4];
    logic                      cs_reg [4];
    logic                      dv3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    for (genvar c = 0; c < 4; c++) begin : g_clamp
        always_ff @(posedge clk)
        begin
            if (t_reg[c] > S_MAX)
            begin
                c_reg[c]  <= DATA_W'(S_MAX);
                cs_reg[c] <= 1'b1;
            end
            else if (t_reg[c] < S_MIN)
            begin
                c_reg[c]  <= DATA_W'(S_MIN);
                cs_reg[c] <= 1'b1;
            end
            else
            begin
                c_reg[c]  <= DATA_W'(t_reg[c]);
                cs_reg[c] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
        dv3_reg <= (t_reg[3] != SW'(FX_ONE64)) && (t_reg[3] != '0);

    // stage 4: magnitudes for the dividers
    logic                      v4_reg;
    logic [QUO_W-1:0]          num_reg [3];
    logic [DATA_W-1:0]         den_reg;
    logic [2:0]                neg_reg;
    logic signed [DATA_W-1:0]  pass_reg [3];
    logic                      dv4_reg;
    logic                      sat4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= c_reg[3][DATA_W-1] ? DATA_W'(-c_reg[3]) : DATA_W'(c_reg[3]);
        dv4_reg  <= dv3_reg;
        sat4_reg <= cs_reg[0] || cs_reg[1] || cs_reg[2] || (dv3_reg && cs_reg[3]);
        for (int i = 0; i < 3; i++)
        begin
            pass_reg[i] <= c_reg[i];
            neg_reg[i]  <= c_reg[i][DATA_W-1] ^ c_reg[3][DATA_W-1];
            num_reg[i]  <= (c_reg[i][DATA_W-1] ? QUO_W'(-(QUO_W'(c_reg[i])))
                                               : QUO_W'(c_reg[i])) << FRAC_BITS;
        end
    end

    // divider lanes with side data delayed alongside
    logic [2:0]        dvld;
    logic [QUO_W-1:0]  quo [3];
    logic [2:0]        qneg;

    for (genvar i = 0; i < 3; i++) begin : g_div
        ptp_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v4_reg),
            .in_num    (num_reg[i]),
            .in_den    (den_reg),
            .in_neg    (neg_reg[i]),
            .out_valid (dvld[i]),
            .out_quo   (quo[i]),
            .out_neg   (qneg[i])
        );
    end

    logic signed [DATA_W-1:0] pd_reg [DIV_STEPS][3];
    logic [DIV_STEPS-1:0]     dd_reg;
    logic [DIV_STEPS-1:0]     sd_reg;

    always_ff @(posedge clk)
    begin
        pd_reg[0] <= pass_reg;
        dd_reg[0] <= dv4_reg;
        sd_reg[0] <= sat4_reg;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            pd_reg[k] <= pd_reg[k-1];
            dd_reg[k] <= dd_reg[k-1];
            sd_reg[k] <= sd_reg[k-1];
        end
    end

    // output stage: sign, clamp, pick
    localparam logic [QUO_W:0] Q_MAX = (QUO_W+1)'((longint'(1) <<< (DATA_W-1)) - 1);
    localparam logic [QUO_W:0] Q_MIN = Q_MAX + (QUO_W+1)'(1);

    logic                      done_reg;
    result_t                   res_reg;
    logic [2:0]                qs;
    logic signed [DATA_W-1:0]  qv [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!qneg[i] && {1'b0, quo[i]} > Q_MAX)
            begin
                qv[i] = DATA_W'(Q_MAX);
                qs[i] = 1'b1;
            end
            else if (qneg[i] && {1'b0, quo[i]} > Q_MIN)
            begin
                qv[i] = DATA_W'(Q_MIN);
                qs[i] = 1'b1;
            end
            else
            begin
                qv[i] = qneg[i] ? DATA_W'(-quo[i]) : DATA_W'(quo[i]);
                qs[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dvld[0];
    end

    always_ff @(posedge clk)
    begin
        if (dd_reg[DIV_STEPS-1])
        begin
            res_reg.out_x <= qv[0];
            res_reg.out_y <= qv[1];
            res_reg.out_z <= qv[2];
            res_reg.saturated <= sd_reg[DIV_STEPS-1] || (|qs);
        end
        else
        begin
            res_reg.out_x <= pd_reg[DIV_STEPS-1][0];
            res_reg.out_y <= pd_reg[DIV_STEPS-1][1];
            res_reg.out_z <= pd_reg[DIV_STEPS-1][2];
            res_reg.saturated <= sd_reg[DIV_STEPS-1];
        end
        res_reg.divide_applied <= dd_reg[DIV_STEPS-1];
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        dvld[0] == dvld[1] && dvld[1] == dvld[2])
        else $error("divider lanes out of step");
    a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |=> v4_reg)
        else $error("beat lost between clamp and divider entry");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        dvld[0] |=> done)
        else $error("divider result not strobed out");

endmodule
